// ----- sv/epwa_pkg.sv -----
// ----------------------------------------------------------------------------
// Echo pulse width averager package
// Beat types, configuration defaults, register indexes and scaling constants.
// ----------------------------------------------------------------------------
package epwa_pkg;

  // Input beat: one tick sample or a start request.
  typedef struct packed {
    logic req_type;
    logic echo_level;
    logic slow_tick;
  } epwa_in_t;

  // Result beat: one finished measurement.
  typedef struct packed {
    logic [15:0] pulse_width;
    logic        timed_out;
    logic [14:0] distance;
  } epwa_out_t;

  // Configuration as seen by the measurement logic.
  typedef struct packed {
    logic [15:0] count_limit;
    logic [7:0]  timeout_ticks;
  } epwa_cfg_t;

  // Measurement phases.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_MEAS = 2'd2
  } phase_e;

  // Request codes carried in req_type.
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_START = 1'b1;

  // Register indexes (word address bit 2).
  localparam logic REG_COUNT_LIMIT   = 1'b0;
  localparam logic REG_TIMEOUT_TICKS = 1'b1;

  // Register reset values.
  localparam logic [15:0] COUNT_LIMIT_RST   = 16'd5000;
  localparam logic [7:0]  TIMEOUT_TICKS_RST = 8'd5;

  // floor(avg * 20 / 50) = floor(2 * avg / 5), done as a reciprocal multiply.
  // ceil(2^20 / 5) is exact for every 17-bit dividend.
  localparam int unsigned  DIST_SHIFT = 20;
  localparam logic [17:0]  DIST_RECIP = 18'd209716;

endpackage

// ----- sv/epwa_regs.sv -----
// ----------------------------------------------------------------------------
// Echo pulse width averager configuration registers
// APB-style register file holding the count limit and the timeout ticks.
// ----------------------------------------------------------------------------
module epwa_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output epwa_pkg::epwa_cfg_t cfg_o
);

  logic [15:0] count_limit_q;
  logic [7:0]  timeout_ticks_q;
  logic        wr_en;

  // The port never inserts wait states.
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Register writes, decoded on the word address.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_limit_q   <= epwa_pkg::COUNT_LIMIT_RST;
      timeout_ticks_q <= epwa_pkg::TIMEOUT_TICKS_RST;
    end else if (wr_en) begin
      case (paddr[2])
        epwa_pkg::REG_COUNT_LIMIT:   count_limit_q   <= pwdata[15:0];
        epwa_pkg::REG_TIMEOUT_TICKS: timeout_ticks_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read data.
  always_comb begin
    case (paddr[2])
      epwa_pkg::REG_COUNT_LIMIT:   prdata = {16'd0, count_limit_q};
      epwa_pkg::REG_TIMEOUT_TICKS: prdata = {24'd0, timeout_ticks_q};
      default:                     prdata = 32'd0;
    endcase
  end

  assign cfg_o.count_limit   = count_limit_q;
  assign cfg_o.timeout_ticks = timeout_ticks_q;

endmodule

// ----- sv/epwa_meas.sv -----
// ----------------------------------------------------------------------------
// Echo pulse width averager measurement stage
// Phase tracking, width counting, the width ring and its running sum.
// ----------------------------------------------------------------------------
module epwa_meas #(
  parameter int unsigned SAMPLES = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                in_valid_i,
  input  epwa_pkg::epwa_in_t  in_data_i,
  input  epwa_pkg::epwa_cfg_t cfg_i,
  output logic                s1_valid_o,
  output logic [15:0]         s1_width_o,
  output logic                s1_flag_o,
  output logic [16+$clog2(SAMPLES)-1:0] s1_sum_o
);

  localparam int unsigned SUM_W = 16 + $clog2(SAMPLES);
  localparam int unsigned PTR_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

  epwa_pkg::phase_e phase_q, phase_d;
  logic [15:0]      count_q, count_d;
  logic [7:0]       tleft_q, tleft_d;
  logic [PTR_W-1:0] ptr_q;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [15:0]      ring_q [SAMPLES];

  logic        go;
  logic        fin;
  logic        fin_flag;
  logic [15:0] fin_width;
  logic [15:0] cnt_inc;
  logic [7:0]  tl_dec;

  logic             s1_valid_q;
  logic [15:0]      s1_width_q;
  logic             s1_flag_q;
  logic [SUM_W-1:0] s1_sum_q;

  assign go = adv_i & in_valid_i;

  // Saturating count and the timeout decrement on a slow tick.
  assign cnt_inc = (count_q == 16'hFFFF) ? count_q : count_q + 16'd1;
  assign tl_dec  = (in_data_i.slow_tick && (tleft_q != 8'd0)) ? tleft_q - 8'd1 : tleft_q;

  // Phase machine for one beat.
  always_comb begin
    phase_d   = phase_q;
    count_d   = count_q;
    tleft_d   = tleft_q;
    fin       = 1'b0;
    fin_flag  = 1'b0;
    fin_width = count_q;
    if (in_data_i.req_type == epwa_pkg::REQ_START) begin
      phase_d = epwa_pkg::PH_WAIT;
      count_d = 16'd0;
      tleft_d = cfg_i.timeout_ticks;
    end else begin
      case (phase_q)
        epwa_pkg::PH_WAIT: begin
          if (in_data_i.echo_level) begin
            phase_d = epwa_pkg::PH_MEAS;
            count_d = 16'd0;
            tleft_d = cfg_i.timeout_ticks;
          end else if ((cnt_inc > cfg_i.count_limit) || (tl_dec == 8'd0)) begin
            phase_d = epwa_pkg::PH_MEAS;
            count_d = 16'd0;
            tleft_d = cfg_i.timeout_ticks;
          end else begin
            count_d = cnt_inc;
            tleft_d = tl_dec;
          end
        end
        epwa_pkg::PH_MEAS: begin
          tleft_d = tl_dec;
          if (!in_data_i.echo_level) begin
            fin       = 1'b1;
            fin_width = count_q;
            phase_d   = epwa_pkg::PH_IDLE;
          end else begin
            count_d = cnt_inc;
            if (cnt_inc > cfg_i.count_limit) begin
              fin       = 1'b1;
              fin_flag  = 1'b1;
              fin_width = cnt_inc;
              phase_d   = epwa_pkg::PH_IDLE;
            end else if (tl_dec == 8'd0) begin
              fin       = 1'b1;
              fin_flag  = 1'b1;
              fin_width = cfg_i.count_limit;
              phase_d   = epwa_pkg::PH_IDLE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Running sum replaces the oldest ring entry with the new width.
  assign sum_d = sum_q - SUM_W'(ring_q[ptr_q]) + SUM_W'(fin_width);

  // Measurement state, ring and pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= epwa_pkg::PH_IDLE;
      count_q <= 16'd0;
      tleft_q <= 8'd0;
      ptr_q   <= '0;
      sum_q   <= '0;
      for (int i = 0; i < SAMPLES; i++) begin
        ring_q[i] <= 16'd0;
      end
    end else if (go) begin
      phase_q <= phase_d;
      count_q <= count_d;
      tleft_q <= tleft_d;
      if (fin) begin
        sum_q         <= sum_d;
        ring_q[ptr_q] <= fin_width;
        ptr_q         <= (ptr_q == PTR_W'(SAMPLES - 1)) ? '0 : ptr_q + PTR_W'(1);
      end
    end
  end

  // Result stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q <= go & fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_width_q <= fin_width;
      s1_flag_q  <= fin_flag;
      s1_sum_q   <= sum_d;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_width_o = s1_width_q;
  assign s1_flag_o  = s1_flag_q;
  assign s1_sum_o   = s1_sum_q;

endmodule

// ----- sv/epwa_scale.sv -----
// ----------------------------------------------------------------------------
// Echo pulse width averager distance scaling
// Two multiply stages: sum / SAMPLES, then the 20/50 scale into the result.
// ----------------------------------------------------------------------------
module epwa_scale #(
  parameter int unsigned SAMPLES = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                s1_valid_i,
  input  logic [15:0]         s1_width_i,
  input  logic                s1_flag_i,
  input  logic [16+$clog2(SAMPLES)-1:0] s1_sum_i,
  output logic                out_valid_o,
  output epwa_pkg::epwa_out_t out_data_o
);

  localparam int unsigned SUM_W  = 16 + $clog2(SAMPLES);
  localparam int unsigned SHIFT  = SUM_W + $clog2(SAMPLES);
  localparam int unsigned RCP_W  = SUM_W + 1;
  localparam int unsigned RECIP  = ((1 << SHIFT) + SAMPLES - 1) / SAMPLES;
  localparam int unsigned PROD_W = SUM_W + RCP_W;

  logic [PROD_W-1:0] avg_prod;
  logic [34:0]       dist_prod;
  logic [16:0]       avg_x2;

  logic        s2_valid_q;
  logic [15:0] s2_width_q;
  logic        s2_flag_q;
  logic [15:0] s2_avg_q;

  logic                out_valid_q;
  epwa_pkg::epwa_out_t out_q;

  // Average: exact floor(sum / SAMPLES) by a rounded-up reciprocal.
  assign avg_prod = PROD_W'(s1_sum_i) * PROD_W'(RCP_W'(RECIP));

  // Distance: floor(2 * avg / 5).
  assign avg_x2    = {s2_avg_q, 1'b0};
  assign dist_prod = 35'(avg_x2) * 35'(epwa_pkg::DIST_RECIP);

  // Valid bits for the two stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      s2_valid_q  <= s1_valid_i;
      out_valid_q <= s2_valid_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s2_width_q        <= s1_width_i;
      s2_flag_q         <= s1_flag_i;
      s2_avg_q          <= avg_prod[SHIFT +: 16];
      out_q.pulse_width <= s2_width_q;
      out_q.timed_out   <= s2_flag_q;
      out_q.distance    <= dist_prod[epwa_pkg::DIST_SHIFT +: 15];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- sv/echo_pulse_width_averager_top.sv -----
// Result: after the input register takes the finishing beat, it passes the ring update, average and scale registers.
// Throughput: one input beat per cycle; the four-register pipeline (input, ring update,
// average multiply, scale multiply) advances whenever the output register is free or taken.
// A held result stalls the whole pipeline, so in_ready_o follows out_ready_i in that case.
// Reset clears the phase to idle, the width ring, pointer and running sum to zero, and
// loads count_limit = 5000 and timeout_ticks = 5.
// ----------------------------------------------------------------------------
// Echo pulse width averager top level
// Times ultrasonic echo pulses and reports the width with an averaged distance.
// ----------------------------------------------------------------------------
module echo_pulse_width_averager_top #(
  parameter int unsigned SAMPLES = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  epwa_pkg::epwa_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output epwa_pkg::epwa_out_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned SUM_W = 16 + $clog2(SAMPLES);

  epwa_pkg::epwa_cfg_t cfg;
  epwa_pkg::epwa_in_t  in_q;
  logic                in_valid_q;
  logic                adv;
  logic                s1_valid;
  logic [15:0]         s1_width;
  logic                s1_flag;
  logic [SUM_W-1:0]    s1_sum;

  // The pipeline moves when the output register can take a new beat.
  assign adv        = ~out_valid_o | out_ready_i;
  assign in_ready_o = adv;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (adv) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q <= in_data_i;
    end
  end

  epwa_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  epwa_meas #(
    .SAMPLES (SAMPLES)
  ) u_meas (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_valid_i (in_valid_q),
    .in_data_i  (in_q),
    .cfg_i      (cfg),
    .s1_valid_o (s1_valid),
    .s1_width_o (s1_width),
    .s1_flag_o  (s1_flag),
    .s1_sum_o   (s1_sum)
  );

  epwa_scale #(
    .SAMPLES (SAMPLES)
  ) u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .s1_valid_i  (s1_valid),
    .s1_width_i  (s1_width),
    .s1_flag_i   (s1_flag),
    .s1_sum_i    (s1_sum),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
